// ----- hw/rtl/periodic_pattern_inserter_assert.svh -----
// Assertion macros used by the checker of this block.
`ifndef PERIODIC_PATTERN_INSERTER_ASSERT_SVH
`define PERIODIC_PATTERN_INSERTER_ASSERT_SVH

// Same-cycle implication.
`define PPI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("periodic_pattern_inserter: check failed");

// Next-cycle implication.
`define PPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("periodic_pattern_inserter: check failed");

`endif

// ----- hw/rtl/ppi_pkg.sv -----
`default_nettype none
package ppi_pkg;

   localparam int PATTERN_MAX    = 32;
   localparam int STORE_AW       = $clog2(PATTERN_MAX);
   localparam int POSITION_WIDTH = 16;
   localparam int LEN_WIDTH      = 6;
   localparam int INDEX_WIDTH    = 5;
   localparam int WORD_WIDTH     = 32;
   localparam int DATA_WIDTH     = 32;
   localparam int ADDR_WIDTH     = 5;
   localparam int REG_SEL_WIDTH  = 3;

   typedef enum logic [REG_SEL_WIDTH-1:0] {
      REG_PATTERN_LENGTH = 3'd0,
      REG_PERIOD         = 3'd1,
      REG_START_OFFSET   = 3'd2,
      REG_PATTERN_INDEX  = 3'd3,
      REG_PATTERN_VALUE  = 3'd4
   } reg_index_type;

   // Effective frame settings after clamping.
   typedef struct packed {
      logic [POSITION_WIDTH-1:0] period;
      logic [LEN_WIDTH-1:0]      length;
   } cfg_type;

   typedef struct packed {
      logic                  en;
      logic [STORE_AW-1:0]   addr;
      logic [WORD_WIDTH-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic                      en;
      logic [POSITION_WIDTH-1:0] value;
   } pos_load_type;

   typedef struct packed {
      logic start_pat;
      logic pass;
      logic emit_pat;
      logic emit_smp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic pat_due;
      logic pat_last;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ppi_req_if.sv -----
`default_nettype none
interface ppi_req_if
   import ppi_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ppi_rsp_if.sv -----
`default_nettype none
interface ppi_rsp_if
   import ppi_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] word;
   logic                  from_pattern;
   logic                  last;

   modport source (output valid, output word, output from_pattern, output last, input ready);
   modport sink (input valid, input word, input from_pattern, input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ppi_csr.sv -----
`default_nettype none
module ppi_csr
   import ppi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_WIDTH-1:0] paddr,
   input  wire logic [DATA_WIDTH-1:0] pwdata,
   output logic      [DATA_WIDTH-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg,
   output store_wr_type               store_wr,
   output pos_load_type               pos_load
);

   logic [LEN_WIDTH-1:0]      length_ff, length_in;
   logic [POSITION_WIDTH-1:0] period_ff, period_in;
   logic [POSITION_WIDTH-1:0] start_ff, start_in;
   logic [INDEX_WIDTH-1:0]    index_ff, index_in;
   logic [WORD_WIDTH-1:0]     value_ff, value_in;

   logic                      wr;
   reg_index_type             sel;
   logic [POSITION_WIDTH-1:0] p_eff;
   logic [POSITION_WIDTH-1:0] p_m1;
   logic [LEN_WIDTH-1:0]      len_cap;
   logic [POSITION_WIDTH-1:0] new_start;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign sel    = reg_index_type'(paddr[ADDR_WIDTH-1:2]);

   assign p_eff     = (period_ff == '0) ? POSITION_WIDTH'(1) : period_ff;
   assign p_m1      = p_eff - POSITION_WIDTH'(1);
   assign len_cap   = (length_ff > LEN_WIDTH'(PATTERN_MAX)) ? LEN_WIDTH'(PATTERN_MAX) : length_ff;
   assign new_start = pwdata[POSITION_WIDTH-1:0];

   assign cfg.period = p_eff;
   assign cfg.length = (POSITION_WIDTH'(len_cap) > p_m1) ? p_m1[LEN_WIDTH-1:0] : len_cap;

   // Reload the frame position whenever the start offset is written.
   assign pos_load.en    = wr && (sel == REG_START_OFFSET);
   assign pos_load.value = (new_start >= p_eff) ? p_m1 : new_start;

   assign store_wr.en   = wr && (sel == REG_PATTERN_VALUE);
   assign store_wr.addr = index_ff[STORE_AW-1:0];
   assign store_wr.data = pwdata[WORD_WIDTH-1:0];

   always_comb begin
      length_in = length_ff;
      period_in = period_ff;
      start_in  = start_ff;
      index_in  = index_ff;
      value_in  = value_ff;
      if (wr) begin
         case (sel)
            REG_PATTERN_LENGTH: length_in = pwdata[LEN_WIDTH-1:0];
            REG_PERIOD:         period_in = pwdata[POSITION_WIDTH-1:0];
            REG_START_OFFSET:   start_in  = pwdata[POSITION_WIDTH-1:0];
            REG_PATTERN_INDEX:  index_in  = pwdata[INDEX_WIDTH-1:0];
            REG_PATTERN_VALUE:  value_in  = pwdata[WORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_PATTERN_LENGTH: prdata = DATA_WIDTH'(length_ff);
         REG_PERIOD:         prdata = DATA_WIDTH'(period_ff);
         REG_START_OFFSET:   prdata = DATA_WIDTH'(start_ff);
         REG_PATTERN_INDEX:  prdata = DATA_WIDTH'(index_ff);
         REG_PATTERN_VALUE:  prdata = DATA_WIDTH'(value_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         period_ff <= POSITION_WIDTH'(1);
         start_ff  <= '0;
         index_ff  <= '0;
         value_ff  <= '0;
      end else begin
         length_ff <= length_in;
         period_ff <= period_in;
         start_ff  <= start_in;
         index_ff  <= index_in;
         value_ff  <= value_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/ppi_ctrl.sv -----
`default_nettype none
module ppi_ctrl
   import ppi_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PAT,
      S_SMP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               if (status.pat_due) begin
                  cmd.start_pat = 1'b1;
                  state_in      = S_PAT;
               end else begin
                  cmd.pass = 1'b1;
               end
            end
         end
         S_PAT: begin
            if (status.out_free) begin
               cmd.emit_pat = 1'b1;
               if (status.pat_last) begin
                  state_in = S_SMP;
               end
            end
         end
         S_SMP: begin
            if (status.out_free) begin
               cmd.emit_smp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/ppi_dp.sv -----
`default_nettype none
module ppi_dp
   import ppi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              status,
   input  wire cfg_type               cfg,
   input  wire store_wr_type          store_wr,
   input  wire pos_load_type          pos_load,
   input  wire logic [WORD_WIDTH-1:0] req_sample,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic      [WORD_WIDTH-1:0] rsp_word,
   output logic                       rsp_from_pattern,
   output logic                       rsp_last
);

   logic [WORD_WIDTH-1:0]     store_ff [PATTERN_MAX];

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [WORD_WIDTH-1:0]     sample_ff, sample_in;
   logic                      valid_ff, valid_in;
   logic [WORD_WIDTH-1:0]     word_ff, word_in;
   logic                      from_pattern_ff, from_pattern_in;
   logic                      last_ff, last_in;

   logic [POSITION_WIDTH-1:0] pos_c;
   logic [POSITION_WIDTH-1:0] pos_inc;
   logic [POSITION_WIDTH-1:0] adv_src;
   logic [POSITION_WIDTH-1:0] adv_inc;
   logic [POSITION_WIDTH-1:0] adv;
   logic [POSITION_WIDTH-1:0] len_ext;
   logic                      load;

   // Restart the frame if the period dropped to or below the held position.
   assign pos_c   = (pos_ff >= cfg.period) ? '0 : pos_ff;
   assign pos_inc = pos_ff + POSITION_WIDTH'(1);
   assign len_ext = POSITION_WIDTH'(cfg.length);
   assign adv_src = cmd.pass ? pos_c : pos_ff;
   assign adv_inc = adv_src + POSITION_WIDTH'(1);
   assign adv     = (adv_inc >= cfg.period) ? '0 : adv_inc;
   assign load    = cmd.pass || cmd.emit_pat || cmd.emit_smp;

   assign status.out_free = !valid_ff || rsp_ready;
   assign status.pat_due  = pos_c < len_ext;
   assign status.pat_last = pos_inc >= len_ext;

   always_comb begin
      if (pos_load.en) begin
         pos_in = pos_load.value;
      end else if (cmd.start_pat) begin
         pos_in = pos_c;
      end else if (cmd.emit_pat) begin
         pos_in = pos_inc;
      end else if (cmd.pass || cmd.emit_smp) begin
         pos_in = adv;
      end else begin
         pos_in = pos_ff;
      end
   end

   assign sample_in = cmd.start_pat ? req_sample : sample_ff;

   always_comb begin
      if (cmd.pass) begin
         word_in = req_sample;
      end else begin
         word_in = sample_ff;
      end
   end

   assign from_pattern_in = cmd.emit_pat;
   assign last_in         = !cmd.emit_pat;
   assign valid_in        = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      // Pattern words go straight from the store into the output register.
      if (cmd.emit_pat) begin
         word_ff <= store_ff[pos_ff[STORE_AW-1:0]];
      end else if (load) begin
         word_ff <= word_in;
      end
      if (load) begin
         from_pattern_ff <= from_pattern_in;
         last_ff         <= last_in;
      end
      if (store_wr.en) begin
         store_ff[store_wr.addr] <= store_wr.data;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_word         = word_ff;
   assign rsp_from_pattern = from_pattern_ff;
   assign rsp_last         = last_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/periodic_pattern_inserter.sv -----
// Datapath: a sample with no pattern due is loaded straight into the output register.
// Throughput: one sample per cycle mid-frame while the output is free; a sample that
// opens a frame waits behind the L pattern words, L being the effective pattern length.
// Reset: synchronous, clears control and config registers to their defaults and the
// frame position to 0; the pattern store is not cleared and must be written before use.
`default_nettype none
module periodic_pattern_inserter
   import ppi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   ppi_req_if.sink                    req_chan,
   ppi_rsp_if.source                  rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_WIDTH-1:0] paddr,
   input  wire logic [DATA_WIDTH-1:0] pwdata,
   output logic      [DATA_WIDTH-1:0] prdata,
   output logic                       pready
);

   cfg_type       cfg;
   store_wr_type  store_wr;
   pos_load_type  pos_load;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   ppi_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg      (cfg),
      .store_wr (store_wr),
      .pos_load (pos_load)
   );

   ppi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ppi_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg              (cfg),
      .store_wr         (store_wr),
      .pos_load         (pos_load),
      .req_sample       (req_chan.sample),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_word         (rsp_chan.word),
      .rsp_from_pattern (rsp_chan.from_pattern),
      .rsp_last         (rsp_chan.last)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/ppi_checker.sv -----
`default_nettype none
`include "periodic_pattern_inserter_assert.svh"
module ppi_checker
   import ppi_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [WORD_WIDTH-1:0] rsp_word,
   input wire logic                  rsp_from_pattern,
   input wire logic                  rsp_last
);

   logic busy_ff, busy_in;
   logic req_acc;
   logic rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Track an accepted sample whose final word is still owed.
   assign busy_in = req_acc ? 1'b1 : ((rsp_acc && rsp_last) ? 1'b0 : busy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   `PPI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word) && $stable(rsp_from_pattern) && $stable(rsp_last))
   `PPI_ASSERT_IMPL(a_last_is_sample, clock, reset, rsp_valid, rsp_from_pattern != rsp_last)
   `PPI_ASSERT_IMPL(a_one_in_flight, clock, reset, req_acc, !busy_ff || (rsp_acc && rsp_last))
   `PPI_ASSERT_IMPL(a_no_orphan_word, clock, reset, rsp_valid, busy_ff)

endmodule

bind periodic_pattern_inserter ppi_checker u_ppi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_word         (rsp_chan.word),
   .rsp_from_pattern (rsp_chan.from_pattern),
   .rsp_last         (rsp_chan.last)
);
`default_nettype wire
